// ===== hw/rtl/tpc_pkg.sv =====
`timescale 1ns / 1ps

package tpc_pkg;

  // Fixed field widths of the geometry stream
  localparam int CoordWidth   = 32;
  localparam int FracBits     = 16;
  localparam int NormWidth    = 18;
  localparam int OffsetWidth  = 32;
  localparam int CfgDataWidth = 32;
  localparam int CfgIdxWidth  = 2;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgNormalX     = 2'd0,
    CfgNormalY     = 2'd1,
    CfgNormalZ     = 2'd2,
    CfgPlaneOffset = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CoordWidth-1:0] p0_x;
    logic signed [CoordWidth-1:0] p0_y;
    logic signed [CoordWidth-1:0] p0_z;
    logic signed [CoordWidth-1:0] p1_x;
    logic signed [CoordWidth-1:0] p1_y;
    logic signed [CoordWidth-1:0] p1_z;
    logic signed [CoordWidth-1:0] p2_x;
    logic signed [CoordWidth-1:0] p2_y;
    logic signed [CoordWidth-1:0] p2_z;
  } tri_in_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] q0_x;
    logic signed [CoordWidth-1:0] q0_y;
    logic signed [CoordWidth-1:0] q0_z;
    logic signed [CoordWidth-1:0] q1_x;
    logic signed [CoordWidth-1:0] q1_y;
    logic signed [CoordWidth-1:0] q1_z;
    logic signed [CoordWidth-1:0] q2_x;
    logic signed [CoordWidth-1:0] q2_y;
    logic signed [CoordWidth-1:0] q2_z;
    logic                         last_of_run;
  } tri_out_t;

endpackage

// ===== hw/rtl/triangle_plane_clipper_unit.sv =====
`timescale 1ns / 1ps

// Triangle clipper against one plane. Pulse start with a triangle while busy
// is low; the beat is taken at that edge. Each vertex gets the signed distance
// floor(dot(p, n) / 2^16) - plane_offset, vertices below zero are dropped, and
// 0, 1 or 2 triangles come out on result_o, each shown for exactly one cycle
// with result_valid_o high; last_of_run marks the final triangle of a beat.
// The receiver cannot hold results off, so nothing stalls from the far side.
// On its way to result_o a beat passes the registers product, distance,
// classify, 17 divider stages (one quotient bit per stage for the edge
// ratio k), edge multiply, edge add and the output register. A new
// triangle is taken every cycle while busy is low; a triangle that splits
// in two holds the whole pipe while its second triangle waits in pend_q,
// and busy is high while the first one is shown. Configuration writes
// are always ready and must only be issued while no triangle is in flight.

module triangle_plane_clipper_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  tpc_pkg::tri_in_t   in_tri_i,
  output logic               result_valid_o,
  output tpc_pkg::tri_out_t  result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  tpc_pkg::cfg_idx_e  cfg_index_i,
  input  logic [tpc_pkg::CfgDataWidth-1:0] cfg_data_i
);
  import tpc_pkg::*;

  // Datapath widths
  localparam int PW    = CoordWidth + NormWidth;    // one product
  localparam int SW    = PW + 2;                    // sum of three products
  localparam int DW    = SW - FracBits + 1;         // distance
  localparam int DenW  = DW + 1;                    // |da| + |db|
  localparam int RW    = DenW + 1;                  // shifted remainder
  localparam int QW    = FracBits + 1;              // k in Q1.16, up to 1.0
  localparam int DiffW = CoordWidth + 1;            // vb - va
  localparam int MW    = DiffW + QW + 1;            // diff * k

  typedef logic [2:0][2:0][CoordWidth-1:0] tri_t;

  typedef enum logic [1:0] {
    ModeNone,   // all vertices dropped
    ModePass,   // none dropped
    ModeOne,    // two dropped: one triangle
    ModeTwo     // one dropped: two triangles
  } mode_e;

  typedef struct packed {
    mode_e                                mode;
    logic [1:0]                           f;
    tri_t                                 v;
    logic [1:0][2:0][CoordWidth-1:0]      va;
    logic [1:0][2:0][DiffW-1:0]           diff;
  } carry_t;

  function automatic logic [1:0] mod3(input logic [2:0] x);
    mod3 = (x >= 3'd3) ? 2'(x - 3'd3) : x[1:0];
  endfunction

  function automatic logic [DW-1:0] abs_d(input logic [DW-1:0] d);
    abs_d = d[DW-1] ? (~d + 1'b1) : d;
  endfunction

  function automatic tri_out_t pack_tri(input tri_t t, input logic last);
    tri_out_t o;
    o.q0_x = t[0][0]; o.q0_y = t[0][1]; o.q0_z = t[0][2];
    o.q1_x = t[1][0]; o.q1_y = t[1][1]; o.q1_z = t[1][2];
    o.q2_x = t[2][0]; o.q2_y = t[2][1]; o.q2_z = t[2][2];
    o.last_of_run = last;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [NormWidth-1:0]   norm_q [3];
  logic signed [OffsetWidth-1:0] offset_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_q[0] <= '0;
      norm_q[1] <= '0;
      norm_q[2] <= NormWidth'(1 << FracBits);
      offset_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgNormalX:     norm_q[0] <= cfg_data_i[NormWidth-1:0];
        CfgNormalY:     norm_q[1] <= cfg_data_i[NormWidth-1:0];
        CfgNormalZ:     norm_q[2] <= cfg_data_i[NormWidth-1:0];
        CfgPlaneOffset: offset_q  <= cfg_data_i[OffsetWidth-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Global advance: the whole pipe freezes for the second triangle of a split
  // ---------------------------------------------------------------------------
  logic hold_q;
  logic adv;

  assign adv  = !hold_q;
  assign busy = hold_q;

  tri_t v_in;
  always_comb begin
    v_in[0][0] = in_tri_i.p0_x; v_in[0][1] = in_tri_i.p0_y; v_in[0][2] = in_tri_i.p0_z;
    v_in[1][0] = in_tri_i.p1_x; v_in[1][1] = in_tri_i.p1_y; v_in[1][2] = in_tri_i.p1_z;
    v_in[2][0] = in_tri_i.p2_x; v_in[2][1] = in_tri_i.p2_y; v_in[2][2] = in_tri_i.p2_z;
  end

  // ---------------------------------------------------------------------------
  // Stage A: nine coordinate-by-normal products
  // ---------------------------------------------------------------------------
  logic              a_vld_q;
  tri_t              a_v_q;
  logic signed [PW-1:0] a_p_q [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_v_q <= v_in;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          a_p_q[i][j] <= $signed(v_in[i][j]) * norm_q[j];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: exact sum, single floor, subtract the plane offset
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0]          sum_b [3];
  logic signed [SW-FracBits-1:0] flo_b [3];
  logic signed [DW-1:0]          d_b   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_b[i] = SW'(a_p_q[i][0]) + SW'(a_p_q[i][1]) + SW'(a_p_q[i][2]);
      flo_b[i] = sum_b[i][SW-1:FracBits];
      d_b[i]   = DW'(flo_b[i]) - DW'(offset_q);
    end
  end

  logic              b_vld_q;
  tri_t              b_v_q;
  logic [DW-1:0]     b_d_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (adv) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_v_q <= a_v_q;
      for (int i = 0; i < 3; i++) begin
        b_d_q[i] <= d_b[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: classify, pick both edges to cut, form ratio operands and deltas
  // ---------------------------------------------------------------------------
  logic [2:0]        disc_c;
  logic [1:0]        cnt_c;
  logic [1:0]        f_c;
  logic [1:0]        ea_c [2];
  logic [1:0]        eb_c [2];
  logic [DW-1:0]     num_c [2];
  logic [DenW-1:0]   den_c [2];
  carry_t            car_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      disc_c[i] = b_d_q[i][DW-1];
    end
    cnt_c = 2'(disc_c[0]) + 2'(disc_c[1]) + 2'(disc_c[2]);
    f_c   = '0;
    for (int i = 0; i < 3; i++) begin
      if (disc_c[i] && !disc_c[mod3(3'(i + 2))]) begin
        f_c = 2'(i);
      end
    end

    car_c.f = f_c;
    car_c.v = b_v_q;
    case (cnt_c)
      2'd0:    car_c.mode = ModePass;
      2'd1:    car_c.mode = ModeTwo;
      2'd2:    car_c.mode = ModeOne;
      default: car_c.mode = ModeNone;
    endcase

    // Edge 0 always runs from f toward f+2; edge 1 depends on the case
    ea_c[0] = f_c;
    eb_c[0] = mod3({1'b0, f_c} + 3'd2);
    if (cnt_c == 2'd2) begin
      ea_c[1] = mod3({1'b0, f_c} + 3'd1);
      eb_c[1] = mod3({1'b0, f_c} + 3'd2);
    end else begin
      ea_c[1] = f_c;
      eb_c[1] = mod3({1'b0, f_c} + 3'd1);
    end

    for (int e = 0; e < 2; e++) begin
      num_c[e] = abs_d(b_d_q[ea_c[e]]);
      den_c[e] = DenW'(num_c[e]) + DenW'(abs_d(b_d_q[eb_c[e]]));
      for (int j = 0; j < 3; j++) begin
        car_c.va[e][j]   = b_v_q[ea_c[e]][j];
        car_c.diff[e][j] = DiffW'($signed(b_v_q[eb_c[e]][j]))
                         - DiffW'($signed(b_v_q[ea_c[e]][j]));
      end
    end
  end

  logic              c_vld_q;
  carry_t            c_car_q;
  logic [DW-1:0]     c_num_q [2];
  logic [DenW-1:0]   c_den_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (adv) begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_car_q <= car_c;
      for (int e = 0; e < 2; e++) begin
        c_num_q[e] <= num_c[e];
        c_den_q[e] <= den_c[e];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Divider: one quotient bit per stage, both edges side by side.
  // Stage 0 settles the integer bit (k = 1.0 when the far vertex sits on the
  // plane), the remaining stages produce the fraction bits.
  // ---------------------------------------------------------------------------
  logic              dv_vld_q [QW];
  carry_t            dv_car_q [QW];
  logic [DenW-1:0]   dv_r_q   [QW][2];
  logic [DenW-1:0]   dv_den_q [QW][2];
  logic [QW-1:0]     dv_q_q   [QW][2];

  logic [DenW-1:0]   dv_r_d   [QW][2];
  logic [QW-1:0]     dv_q_d   [QW][2];
  logic [RW-1:0]     dv_sh    [QW][2];
  logic              dv_bit   [QW][2];

  always_comb begin
    for (int e = 0; e < 2; e++) begin
      dv_sh[0][e]  = RW'(c_num_q[e]);
      dv_bit[0][e] = (dv_sh[0][e] >= RW'(c_den_q[e]));
      dv_r_d[0][e] = dv_bit[0][e] ? DenW'(dv_sh[0][e] - RW'(c_den_q[e]))
                                  : DenW'(dv_sh[0][e]);
      dv_q_d[0][e] = QW'(dv_bit[0][e]);
    end
    for (int s = 1; s < QW; s++) begin
      for (int e = 0; e < 2; e++) begin
        dv_sh[s][e]  = {dv_r_q[s-1][e], 1'b0};
        dv_bit[s][e] = (dv_sh[s][e] >= RW'(dv_den_q[s-1][e]));
        dv_r_d[s][e] = dv_bit[s][e] ? DenW'(dv_sh[s][e] - RW'(dv_den_q[s-1][e]))
                                    : DenW'(dv_sh[s][e]);
        dv_q_d[s][e] = {dv_q_q[s-1][e][QW-2:0], dv_bit[s][e]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < QW; s++) begin
        dv_vld_q[s] <= 1'b0;
      end
    end else if (adv) begin
      dv_vld_q[0] <= c_vld_q;
      for (int s = 1; s < QW; s++) begin
        dv_vld_q[s] <= dv_vld_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_car_q[0] <= c_car_q;
      for (int e = 0; e < 2; e++) begin
        dv_r_q[0][e]   <= dv_r_d[0][e];
        dv_q_q[0][e]   <= dv_q_d[0][e];
        dv_den_q[0][e] <= c_den_q[e];
      end
      for (int s = 1; s < QW; s++) begin
        dv_car_q[s] <= dv_car_q[s-1];
        for (int e = 0; e < 2; e++) begin
          dv_r_q[s][e]   <= dv_r_d[s][e];
          dv_q_q[s][e]   <= dv_q_d[s][e];
          dv_den_q[s][e] <= dv_den_q[s-1][e];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage M: delta times k
  // ---------------------------------------------------------------------------
  logic              m_vld_q;
  carry_t            m_car_q;
  logic signed [MW-1:0] m_p_q [2][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (adv) begin
      m_vld_q <= dv_vld_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_car_q <= dv_car_q[QW-1];
      for (int e = 0; e < 2; e++) begin
        for (int j = 0; j < 3; j++) begin
          m_p_q[e][j] <= $signed(dv_car_q[QW-1].diff[e][j])
                       * $signed({1'b0, dv_q_q[QW-1][e]});
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage S: edge points and output triangle assembly
  // ---------------------------------------------------------------------------
  logic [2:0][CoordWidth-1:0] ept_s [2];
  tri_t       t0_s;
  tri_t       t1_s;
  logic [1:0] f1_s;
  logic [1:0] f2_s;

  always_comb begin
    for (int e = 0; e < 2; e++) begin
      for (int j = 0; j < 3; j++) begin
        // Low bits of the floored product are all the wrapped sum needs
        ept_s[e][j] = m_car_q.va[e][j] + m_p_q[e][j][FracBits+CoordWidth-1:FracBits];
      end
    end
    f1_s = mod3({1'b0, m_car_q.f} + 3'd1);
    f2_s = mod3({1'b0, m_car_q.f} + 3'd2);
    t0_s = m_car_q.v;
    t1_s = m_car_q.v;
    case (m_car_q.mode)
      ModeOne: begin
        for (int i = 0; i < 3; i++) begin
          if (2'(i) == m_car_q.f) begin
            t0_s[i] = ept_s[0];
          end else if (2'(i) == f1_s) begin
            t0_s[i] = ept_s[1];
          end else begin
            t0_s[i] = m_car_q.v[i];
          end
        end
      end
      ModeTwo: begin
        t0_s[0] = m_car_q.v[f2_s];
        t0_s[1] = ept_s[0];
        t0_s[2] = ept_s[1];
        t1_s[0] = m_car_q.v[f2_s];
        t1_s[1] = ept_s[1];
        t1_s[2] = m_car_q.v[f1_s];
      end
      default: ;
    endcase
  end

  logic   s_vld_q;
  mode_e  s_mode_q;
  tri_t   s_t0_q;
  tri_t   s_t1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q <= 1'b0;
    end else if (adv) begin
      s_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_mode_q <= m_car_q.mode;
      s_t0_q   <= t0_s;
      s_t1_q   <= t1_s;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: first triangle goes out, the second waits in pend_q
  // while the pipe holds
  // ---------------------------------------------------------------------------
  logic     out_vld_q;
  tri_out_t out_q;
  tri_t     pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      hold_q    <= 1'b0;
    end else if (hold_q) begin
      out_vld_q <= 1'b1;
      hold_q    <= 1'b0;
    end else begin
      out_vld_q <= s_vld_q && (s_mode_q != ModeNone);
      hold_q    <= s_vld_q && (s_mode_q == ModeTwo);
    end
  end

  always_ff @(posedge clk_i) begin
    if (hold_q) begin
      out_q <= pack_tri(pend_q, 1'b1);
    end else begin
      out_q  <= pack_tri(s_t0_q, s_mode_q != ModeTwo);
      pend_q <= s_t1_q;
    end
  end

  assign result_valid_o = out_vld_q;
  assign result_o       = out_q;

endmodule

// ===== hw/rtl/tpc_checker.sv =====
`timescale 1ns / 1ps

module tpc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               busy,
  input logic               result_valid_o,
  input tpc_pkg::tri_out_t  result_o
);

  // Busy is high only while the first triangle of a split is on the output
  a_busy_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  a_busy_first_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (result_valid_o && !result_o.last_of_run))
    else $error("busy without the first triangle of a split on the output");

  a_busy_second_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (result_valid_o && result_o.last_of_run))
    else $error("second triangle of a split missing");

  a_nonlast_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.last_of_run) |-> busy)
    else $error("non-final triangle without busy");

endmodule

bind triangle_plane_clipper_unit tpc_checker u_tpc_checker (.*);
